// ===== design/ucs_pkg.sv =====
// ----------------------------------------------------------------------------
// ucs_pkg: unitig coverage statistic shared definitions
// Widths, fixed-point constants and the controller/datapath command types.
// ----------------------------------------------------------------------------
package ucs_pkg;

   localparam int COORD_BITS    = 28;
   localparam int COUNT_BITS    = 20;
   localparam int RATE_BITS     = 32;
   localparam int RHO_BITS      = COORD_BITS + 1;
   localparam int DIST_FRAC     = 7;
   localparam int DIV_BITS      = RHO_BITS + DIST_FRAC;
   localparam int DIV_CNT_BITS  = $clog2(DIV_BITS);
   localparam int MUL_BITS      = 32;
   localparam int PROD_BITS     = 2 * MUL_BITS;
   localparam int RND_SHIFT     = 16;
   localparam int MAG_BITS      = PROD_BITS - RND_SHIFT + 1;
   localparam int STAT_BITS     = 48;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [MUL_BITS-1:0] LN2_Q32 = 32'd2977044472;

   localparam logic [MAG_BITS-1:0] STAT_POS_MAX =
      (MAG_BITS'(1) << (STAT_BITS - 1)) - MAG_BITS'(1);
   localparam logic [MAG_BITS-1:0] STAT_NEG_MAG = MAG_BITS'(1) << (STAT_BITS - 1);

   // register index decoded from paddr[2]
   localparam logic CSR_IDX_RATE = 1'b0;

   typedef struct packed {
      logic fold;
      logic span;
      logic mul_rho;
      logic mul_ln2;
      logic sub;
      logic rnd;
      logic sat;
      logic div_init;
      logic div_step;
      logic load_out;
   } ucs_cmd_type;

   typedef struct packed {
      logic out_free;
   } ucs_status_type;

endpackage

// ===== design/ucs_req_if.sv =====
// ----------------------------------------------------------------------------
// ucs_req_if: fragment placement channel
// Valid/ready channel carrying one fragment placement per transaction.
// ----------------------------------------------------------------------------
interface ucs_req_if;
   logic                           valid;
   logic                           ready;
   logic [ucs_pkg::COORD_BITS-1:0] frag_first_coord;
   logic [ucs_pkg::COORD_BITS-1:0] frag_second_coord;
   logic                           is_random;
   logic                           last_fragment;

   modport source (
      output valid, frag_first_coord, frag_second_coord, is_random, last_fragment,
      input  ready
   );
   modport sink (
      input  valid, frag_first_coord, frag_second_coord, is_random, last_fragment,
      output ready
   );
endinterface

// ===== design/ucs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ucs_rsp_if: unitig statistic result channel
// Valid/ready channel carrying one unitig result per transaction.
// ----------------------------------------------------------------------------
interface ucs_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [ucs_pkg::RHO_BITS-1:0]          rho_twice;
   logic [ucs_pkg::COUNT_BITS-1:0]        random_total;
   logic signed [ucs_pkg::STAT_BITS-1:0]  coverage_stat;
   logic [ucs_pkg::DIV_BITS-1:0]          arrival_distance;
   logic                                  start_not_zero;

   modport source (
      output valid, rho_twice, random_total, coverage_stat, arrival_distance,
             start_not_zero,
      input  ready
   );
   modport sink (
      input  valid, rho_twice, random_total, coverage_stat, arrival_distance,
             start_not_zero,
      output ready
   );
endinterface

// ===== design/ucs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ucs_ctrl: unitig coverage statistic sequencer
// Accepts fragments, then steps the datapath through span, multiply,
// rounding, saturation and the bit-serial divide for each unitig.
// ----------------------------------------------------------------------------
module ucs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   input  ucs_pkg::ucs_status_type status,
   output ucs_pkg::ucs_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SPAN    = 4'd1;
   localparam logic [3:0] ST_MUL_RHO = 4'd2;
   localparam logic [3:0] ST_MUL_LN2 = 4'd3;
   localparam logic [3:0] ST_SUB     = 4'd4;
   localparam logic [3:0] ST_RND     = 4'd5;
   localparam logic [3:0] ST_SAT     = 4'd6;
   localparam logic [3:0] ST_DIV     = 4'd7;
   localparam logic [3:0] ST_DONE    = 4'd8;

   localparam logic [ucs_pkg::DIV_CNT_BITS-1:0] DIV_LAST =
      ucs_pkg::DIV_CNT_BITS'(ucs_pkg::DIV_BITS - 1);

   logic [3:0]                       state_ff, state_in;
   logic [ucs_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.fold = 1'b1;
               if (req_last) begin
                  state_in = ST_SPAN;
               end
            end
         end
         ST_SPAN: begin
            cmd.span = 1'b1;
            state_in = ST_MUL_RHO;
         end
         ST_MUL_RHO: begin
            cmd.mul_rho = 1'b1;
            state_in    = ST_MUL_LN2;
         end
         ST_MUL_LN2: begin
            cmd.mul_ln2 = 1'b1;
            state_in    = ST_SUB;
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_RND;
         end
         ST_RND: begin
            cmd.rnd  = 1'b1;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat      = 1'b1;
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== design/ucs_datapath.sv =====
// ----------------------------------------------------------------------------
// ucs_datapath: unitig coverage statistic datapath
// Running extremes and random count, shared multiplier, rounding and
// saturation of the statistic, restoring divider, result register.
// ----------------------------------------------------------------------------
module ucs_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ucs_pkg::ucs_cmd_type                 cmd,
   output ucs_pkg::ucs_status_type              status,
   input  logic [ucs_pkg::COORD_BITS-1:0]       first_coord,
   input  logic [ucs_pkg::COORD_BITS-1:0]       second_coord,
   input  logic                                 is_random,
   input  logic                                 rate_wr,
   input  logic [ucs_pkg::RATE_BITS-1:0]        rate_wdata,
   output logic [ucs_pkg::RATE_BITS-1:0]        rate,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [ucs_pkg::RHO_BITS-1:0]         out_rho_twice,
   output logic [ucs_pkg::COUNT_BITS-1:0]       out_random_total,
   output logic signed [ucs_pkg::STAT_BITS-1:0] out_coverage_stat,
   output logic [ucs_pkg::DIV_BITS-1:0]         out_arrival_distance,
   output logic                                 out_start_not_zero
);

   localparam int CB = ucs_pkg::COORD_BITS;
   localparam int NB = ucs_pkg::COUNT_BITS;

   // running state
   logic [CB-1:0] least_lower_ff, least_lower_in;
   logic [CB-1:0] greatest_lower_ff, greatest_lower_in;
   logic [CB-1:0] least_upper_ff, least_upper_in;
   logic [CB-1:0] greatest_upper_ff, greatest_upper_in;
   logic [NB-1:0] random_count_ff, random_count_in;
   logic [ucs_pkg::RATE_BITS-1:0] rate_ff, rate_in;

   // per-unitig working registers
   logic [ucs_pkg::RHO_BITS-1:0]  rho2_ff, rho2_in;
   logic [NB-1:0]                 n_ff, n_in;
   logic                          snz_ff, snz_in;
   logic [ucs_pkg::PROD_BITS-1:0] t1_ff, t1_in;
   logic [ucs_pkg::PROD_BITS-1:0] t2_ff, t2_in;
   logic [ucs_pkg::PROD_BITS-1:0] diff_ff, diff_in;
   logic                          neg_ff, neg_in;
   logic [ucs_pkg::MAG_BITS-1:0]  mag_ff, mag_in;
   logic [ucs_pkg::STAT_BITS-1:0] stat_ff, stat_in;
   logic [NB-1:0]                 rem_ff, rem_in;
   logic [ucs_pkg::DIV_BITS-1:0]  quo_ff, quo_in;
   logic [NB-1:0]                 dsr_ff, dsr_in;
   logic                          dist_zero_ff, dist_zero_in;

   // result register
   logic                                 out_valid_ff, out_valid_in;
   logic [ucs_pkg::RHO_BITS-1:0]         o_rho_ff, o_rho_in;
   logic [NB-1:0]                        o_cnt_ff, o_cnt_in;
   logic [ucs_pkg::STAT_BITS-1:0]        o_stat_ff, o_stat_in;
   logic [ucs_pkg::DIV_BITS-1:0]         o_dist_ff, o_dist_in;
   logic                                 o_snz_ff, o_snz_in;

   logic [CB-1:0]                 lo, hi;
   logic [NB-1:0]                 n_minus1;
   logic [ucs_pkg::MUL_BITS-1:0]  mul_a, mul_b;
   logic [ucs_pkg::PROD_BITS-1:0] mul_prod;
   logic [NB:0]                   div_shift;
   logic [ucs_pkg::MAG_BITS-1:0]  mag_lim;

   assign lo       = (first_coord < second_coord) ? first_coord : second_coord;
   assign hi       = (first_coord < second_coord) ? second_coord : first_coord;
   assign n_minus1 = n_ff - 1'b1;
   assign mul_a    = cmd.mul_ln2 ? ucs_pkg::LN2_Q32 : ucs_pkg::MUL_BITS'(rate_ff);
   assign mul_b    = cmd.mul_ln2 ? ucs_pkg::MUL_BITS'(n_minus1)
                                 : ucs_pkg::MUL_BITS'(rho2_ff);
   assign mul_prod = ucs_pkg::PROD_BITS'(mul_a) * ucs_pkg::PROD_BITS'(mul_b);
   assign div_shift = {rem_ff, quo_ff[ucs_pkg::DIV_BITS-1]};

   always_comb begin
      least_lower_in    = least_lower_ff;
      greatest_lower_in = greatest_lower_ff;
      least_upper_in    = least_upper_ff;
      greatest_upper_in = greatest_upper_ff;
      random_count_in   = random_count_ff;
      rate_in           = rate_ff;
      rho2_in           = rho2_ff;
      n_in              = n_ff;
      snz_in            = snz_ff;
      t1_in             = t1_ff;
      t2_in             = t2_ff;
      diff_in           = diff_ff;
      neg_in            = neg_ff;
      mag_in            = mag_ff;
      stat_in           = stat_ff;
      rem_in            = rem_ff;
      quo_in            = quo_ff;
      dsr_in            = dsr_ff;
      dist_zero_in      = dist_zero_ff;
      out_valid_in      = out_valid_ff;
      o_rho_in          = o_rho_ff;
      o_cnt_in          = o_cnt_ff;
      o_stat_in         = o_stat_ff;
      o_dist_in         = o_dist_ff;
      o_snz_in          = o_snz_ff;
      mag_lim           = mag_ff;

      if (rate_wr) begin
         rate_in = rate_wdata;
      end

      if (cmd.fold) begin
         if (lo < least_lower_ff)    least_lower_in    = lo;
         if (lo > greatest_lower_ff) greatest_lower_in = lo;
         if (hi < least_upper_ff)    least_upper_in    = hi;
         if (hi > greatest_upper_ff) greatest_upper_in = hi;
         if (is_random && (random_count_ff != {NB{1'b1}})) begin
            random_count_in = random_count_ff + 1'b1;
         end
      end

      if (cmd.span) begin
         rho2_in = ucs_pkg::RHO_BITS'(greatest_lower_ff - least_lower_ff)
                 + ucs_pkg::RHO_BITS'(greatest_upper_ff - least_upper_ff);
         n_in              = random_count_ff;
         snz_in            = (least_lower_ff != '0);
         least_lower_in    = {CB{1'b1}};
         greatest_lower_in = '0;
         least_upper_in    = {CB{1'b1}};
         greatest_upper_in = '0;
         random_count_in   = '0;
      end

      if (cmd.mul_rho) begin
         t1_in = mul_prod >> 1;
      end
      if (cmd.mul_ln2) begin
         t2_in = mul_prod;
      end

      if (cmd.sub) begin
         if (t1_ff >= t2_ff) begin
            diff_in = t1_ff - t2_ff;
            neg_in  = 1'b0;
         end else begin
            diff_in = t2_ff - t1_ff;
            neg_in  = 1'b1;
         end
      end

      // Q32 to Q16, ties away from zero on the magnitude
      if (cmd.rnd) begin
         mag_in = ucs_pkg::MAG_BITS'(diff_ff >> ucs_pkg::RND_SHIFT)
                + ucs_pkg::MAG_BITS'(diff_ff[ucs_pkg::RND_SHIFT-1]);
      end

      if (cmd.sat) begin
         if ((n_ff == '0) || (rate_ff == '0)) begin
            stat_in = '0;
         end else if (neg_ff) begin
            mag_lim = (mag_ff > ucs_pkg::STAT_NEG_MAG) ? ucs_pkg::STAT_NEG_MAG : mag_ff;
            stat_in = ucs_pkg::STAT_BITS'(ucs_pkg::MAG_BITS'(0) - mag_lim);
         end else begin
            mag_lim = (mag_ff > ucs_pkg::STAT_POS_MAX) ? ucs_pkg::STAT_POS_MAX : mag_ff;
            stat_in = ucs_pkg::STAT_BITS'(mag_lim);
         end
      end

      if (cmd.div_init) begin
         rem_in       = '0;
         quo_in       = {rho2_ff, {ucs_pkg::DIST_FRAC{1'b0}}};
         dsr_in       = n_minus1;
         dist_zero_in = (n_ff <= NB'(1));
      end

      // restoring divide, one quotient bit per step
      if (cmd.div_step) begin
         if (div_shift >= {1'b0, dsr_ff}) begin
            rem_in = NB'(div_shift - {1'b0, dsr_ff});
            quo_in = {quo_ff[ucs_pkg::DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = div_shift[NB-1:0];
            quo_in = {quo_ff[ucs_pkg::DIV_BITS-2:0], 1'b0};
         end
      end

      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         o_rho_in     = rho2_ff;
         o_cnt_in     = n_ff;
         o_stat_in    = stat_ff;
         o_dist_in    = dist_zero_ff ? '0 : quo_ff;
         o_snz_in     = snz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         least_lower_ff    <= {CB{1'b1}};
         greatest_lower_ff <= '0;
         least_upper_ff    <= {CB{1'b1}};
         greatest_upper_ff <= '0;
         random_count_ff   <= '0;
         rate_ff           <= '0;
         out_valid_ff      <= 1'b0;
      end else begin
         least_lower_ff    <= least_lower_in;
         greatest_lower_ff <= greatest_lower_in;
         least_upper_ff    <= least_upper_in;
         greatest_upper_ff <= greatest_upper_in;
         random_count_ff   <= random_count_in;
         rate_ff           <= rate_in;
         out_valid_ff      <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rho2_ff      <= rho2_in;
      n_ff         <= n_in;
      snz_ff       <= snz_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      diff_ff      <= diff_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      stat_ff      <= stat_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dsr_ff       <= dsr_in;
      dist_zero_ff <= dist_zero_in;
      o_rho_ff     <= o_rho_in;
      o_cnt_ff     <= o_cnt_in;
      o_stat_ff    <= o_stat_in;
      o_dist_ff    <= o_dist_in;
      o_snz_ff     <= o_snz_in;
   end

   assign status.out_free      = !out_valid_ff || out_ready;
   assign rate                 = rate_ff;
   assign out_valid            = out_valid_ff;
   assign out_rho_twice        = o_rho_ff;
   assign out_random_total     = o_cnt_ff;
   assign out_coverage_stat    = o_stat_ff;
   assign out_arrival_distance = o_dist_ff;
   assign out_start_not_zero   = o_snz_ff;

endmodule

// ===== design/unitig_coverage_statistic.sv =====
// ----------------------------------------------------------------------------
// unitig_coverage_statistic: per-unitig coverage statistic
// Folds fragment placements of one unitig and reports span, random count,
// coverage statistic, arrival distance and a nonzero-start flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one fragment placement per transaction; last_fragment
//   closes the unitig. rsp_chan carries one result per unitig. global_rate
//   (Q0.32) sits at csr address 0; write it while the block is idle.
//   A fragment without the last mark leaves req_chan.ready high, so a
//   transaction can be accepted every cycle.
//   After a last fragment the block computes the span, makes two
//   passes of a shared 32x32 multiplier, subtracts, rounds, saturates and
//   runs a restoring divide, one quotient bit per cycle, then loads the
//   result register once it is free; req_chan.ready is low meanwhile.
//   The result register frees the input side: if rsp_chan stalls, fragments
//   of the next unitig are still accepted, and only the load of the next
//   result waits for the register to drain.
//   Synchronous reset clears the running values, the rate register and the
//   result valid.
// ----------------------------------------------------------------------------
module unitig_coverage_statistic (
   input  logic                                 clock,
   input  logic                                 reset,
   ucs_req_if.sink                              req_chan,
   ucs_rsp_if.source                            rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ucs_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [ucs_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [ucs_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   ucs_pkg::ucs_cmd_type          cmd;
   ucs_pkg::ucs_status_type       status;
   logic                          rate_wr;
   logic [ucs_pkg::RATE_BITS-1:0] rate;

   assign csr_pready = 1'b1;
   assign rate_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == ucs_pkg::CSR_IDX_RATE);
   assign csr_prdata = (csr_paddr[2] == ucs_pkg::CSR_IDX_RATE) ? rate : '0;

   ucs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_fragment),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ucs_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .first_coord          (req_chan.frag_first_coord),
      .second_coord         (req_chan.frag_second_coord),
      .is_random            (req_chan.is_random),
      .rate_wr              (rate_wr),
      .rate_wdata           (csr_pwdata),
      .rate                 (rate),
      .out_valid            (rsp_chan.valid),
      .out_ready            (rsp_chan.ready),
      .out_rho_twice        (rsp_chan.rho_twice),
      .out_random_total     (rsp_chan.random_total),
      .out_coverage_stat    (rsp_chan.coverage_stat),
      .out_arrival_distance (rsp_chan.arrival_distance),
      .out_start_not_zero   (rsp_chan.start_not_zero)
   );

   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.last_fragment |=> !req_chan.ready)
      else $error("input still ready after last fragment");

   a_mid_streams: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && !req_chan.last_fragment |=> req_chan.ready)
      else $error("input stalled after a middle fragment");

   a_stat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.random_total == '0) |-> (rsp_chan.coverage_stat == '0))
      else $error("coverage statistic nonzero without random fragments");

   a_dist_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.random_total <= 1) |-> (rsp_chan.arrival_distance == '0))
      else $error("arrival distance nonzero with at most one random fragment");

endmodule
